// ----- sv/binomial_coefficient_decimal_float_defines.svh -----
// Assertion macros shared by the binomial coefficient block
`ifndef BINOMIAL_COEFFICIENT_DECIMAL_FLOAT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_DECIMAL_FLOAT_DEFINES_SVH

// same-cycle implication
`define BCDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bcdf_pkg.sv -----
package bcdf_pkg;

    localparam int DEFAULT_OPERAND_BITS = 16;
    localparam int EW    = 8;
    localparam int MW    = 24;
    localparam int QBITS = 26;
    localparam int GBITS = 26;
    localparam int DEXP_W = 16;
    localparam int BIAS  = 127;

    localparam logic [MW-1:0] ONE_M = 24'h800000;
    localparam logic [MW-1:0] TEN_M = 24'hA00000;

    // ceil(2^34 / 5): floor(x / 5) is x * RECIP_FIVE >> 34
    localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;

    typedef logic signed [EW-1:0] t_exp;

    localparam t_exp TEN_E = 8'sd3;

    typedef struct packed {
        t_exp            e;
        logic [MW-1:0]   m;
    } t_fp;

    typedef struct packed {
        logic load;
        logic cvt_ld_top;
        logic cvt_ld_d;
        logic cvt_shift;
        logic cvt_fin;
        logic mul_b;
        logic mul_ten;
        logic mul_rnd;
        logic div_st_b;
        logic div_st_ten;
        logic div_iter;
        logic div_fin;
        logic dexp_inc;
        logic dexp_dec;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic d_gt_k;
        logic cvt_norm;
        logic div_done;
        logic ge_ten;
        logic lt_one;
        logic out_free;
    } t_sts;

    function automatic t_fp fp_round(input logic [MW-1:0] m, input logic g,
                                     input logic s, input t_exp e);
        logic       inc;
        logic [MW:0] sum;
        t_fp        r;
        inc = g & (s | m[0]);
        sum = {1'b0, m} + {{MW{1'b0}}, inc};
        if (sum[MW]) begin
            r.m = ONE_M;
            r.e = e + t_exp'(1);
        end else begin
            r.m = sum[MW-1:0];
            r.e = e;
        end
        return r;
    endfunction

endpackage

// ----- sv/bcdf_ifs.sv -----
interface bcdf_in_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] n_value;
    logic [W-1:0] k_value;
    modport source (output valid, output n_value, output k_value, input ready);
    modport sink (input valid, input n_value, input k_value, output ready);
endinterface

interface bcdf_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        mantissa_bits;
    logic signed [15:0] exponent;
    logic               range_error;
    modport source (output valid, output mantissa_bits, output exponent,
                    output range_error, input ready);
    modport sink (input valid, input mantissa_bits, input exponent,
                  input range_error, output ready);
endinterface

// ----- sv/bcdf_ctrl.sv -----
module bcdf_ctrl
    import bcdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_CVT_TOP, S_MUL, S_MRND, S_CVT_D, S_DIVS, S_DIVI,
        S_NORM, S_M10R, S_NORM2, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_sts.err || i_sts.d_gt_k) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.cvt_ld_top = 1'b1;
                    n_state          = S_CVT_TOP;
                end
            end
            S_CVT_TOP: begin
                if (i_sts.cvt_norm) begin
                    o_cmd.cvt_fin = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    o_cmd.cvt_shift = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_MRND;
            end
            S_MRND: begin
                o_cmd.mul_rnd  = 1'b1;
                o_cmd.cvt_ld_d = 1'b1;
                n_state        = S_CVT_D;
            end
            S_CVT_D: begin
                if (i_sts.cvt_norm) begin
                    o_cmd.cvt_fin = 1'b1;
                    n_state       = S_DIVS;
                end else begin
                    o_cmd.cvt_shift = 1'b1;
                end
            end
            S_DIVS: begin
                o_cmd.div_st_b = 1'b1;
                n_state        = S_DIVI;
            end
            S_DIVI: begin
                if (i_sts.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = S_NORM;
                end else begin
                    o_cmd.div_iter = 1'b1;
                end
            end
            S_NORM: begin
                if (i_sts.ge_ten) begin
                    o_cmd.div_st_ten = 1'b1;
                    o_cmd.dexp_inc   = 1'b1;
                    n_state          = S_DIVI;
                end else if (i_sts.lt_one) begin
                    o_cmd.mul_ten  = 1'b1;
                    o_cmd.dexp_dec = 1'b1;
                    n_state        = S_M10R;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            S_M10R: begin
                o_cmd.mul_rnd = 1'b1;
                n_state       = S_NORM2;
            end
            S_NORM2: begin
                if (i_sts.lt_one) begin
                    o_cmd.mul_ten  = 1'b1;
                    o_cmd.dexp_dec = 1'b1;
                    n_state        = S_M10R;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ----- sv/bcdf_dp.sv -----
module bcdf_dp
    import bcdf_pkg::*;
#(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [OPERAND_BITS-1:0] i_n_value,
    input  logic [OPERAND_BITS-1:0] i_k_value,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [31:0]             o_mantissa_bits,
    output logic signed [15:0]      o_exponent,
    output logic                    o_range_error
);

    localparam int W   = OPERAND_BITS;
    localparam int SW  = W + GBITS;
    localparam int CCW = $clog2(W);
    localparam int QCW = $clog2(QBITS + 1);

    logic [W-1:0]      r_n, r_k, r_top;
    logic [W:0]        r_d;
    logic [SW-1:0]     r_cs;
    logic [CCW-1:0]    r_cc;
    logic [MW-1:0]     r_mm, r_bm, r_dv;
    t_exp              r_me, r_be, r_pe;
    logic [2*MW-1:0]   r_prod;
    logic [MW:0]       r_rem;
    logic [QBITS-1:0]  r_q;
    logic [QCW-1:0]    r_qc;
    logic [DEXP_W-1:0] r_dexp;
    logic              r_ov;
    logic [31:0]       r_om;
    logic [15:0]       r_oe;
    logic              r_oerr;

    t_fp         cvt_fp, mul_fp, div_fp;
    t_exp        cvt_e;
    logic        err;
    logic [MW:0] rem_sub;
    logic        rem_ge;
    logic [MW-1:0] mop_m;
    t_exp          mop_e;
    logic [MW+31:0] ten_p;

    assign err   = r_k > r_n;
    assign cvt_e = t_exp'(W - 1) - t_exp'(r_cc);
    assign cvt_fp = fp_round(r_cs[SW-1 -: MW], r_cs[SW-MW-1], |r_cs[SW-MW-2:0], cvt_e);

    assign mul_fp = r_prod[2*MW-1]
        ? fp_round(r_prod[2*MW-1 -: MW], r_prod[MW-1], |r_prod[MW-2:0], r_pe + t_exp'(1))
        : fp_round(r_prod[2*MW-2 -: MW], r_prod[MW-2], |r_prod[MW-3:0], r_pe);

    assign div_fp = r_q[QBITS-1]
        ? fp_round(r_q[QBITS-1 -: MW], r_q[1], r_q[0] | (|r_rem), r_pe)
        : fp_round(r_q[QBITS-2 -: MW], r_q[0], |r_rem, r_pe - t_exp'(1));

    assign rem_ge  = r_rem >= {1'b0, r_dv};
    assign rem_sub = r_rem - {1'b0, r_dv};
    assign mop_m   = i_cmd.mul_ten ? TEN_M : r_bm;
    assign mop_e   = i_cmd.mul_ten ? TEN_E : r_be;
    assign ten_p   = r_mm * RECIP_FIVE;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_n_value;
            r_k    <= i_k_value;
            r_top  <= i_n_value;
            r_d    <= (W+1)'(1);
            r_mm   <= ONE_M;
            r_me   <= '0;
            r_dexp <= '0;
        end
        if (i_cmd.step) begin
            r_top <= r_top - W'(1);
            r_d   <= r_d + (W+1)'(1);
        end
        if (i_cmd.cvt_ld_top) begin
            r_cs <= {r_top, {GBITS{1'b0}}};
            r_cc <= '0;
        end else if (i_cmd.cvt_ld_d) begin
            r_cs <= {r_d[W-1:0], {GBITS{1'b0}}};
            r_cc <= '0;
        end else if (i_cmd.cvt_shift) begin
            r_cs <= {r_cs[SW-2:0], 1'b0};
            r_cc <= r_cc + CCW'(1);
        end
        if (i_cmd.cvt_fin) begin
            r_bm <= cvt_fp.m;
            r_be <= cvt_fp.e;
        end
        if (i_cmd.mul_b || i_cmd.mul_ten) begin
            r_prod <= r_mm * mop_m;
            r_pe   <= r_me + mop_e;
        end
        if (i_cmd.mul_rnd) begin
            r_mm <= mul_fp.m;
            r_me <= mul_fp.e;
        end
        if (i_cmd.div_st_b) begin
            r_rem <= {1'b0, r_mm};
            r_dv  <= r_bm;
            r_pe  <= r_me - r_be;
            r_q   <= '0;
            r_qc  <= '0;
        end else if (i_cmd.div_st_ten) begin
            r_rem <= {{MW{1'b0}}, |ten_p[29:26]};
            r_pe  <= r_me - TEN_E;
            r_q   <= ten_p[MW+31 -: QBITS];
            r_qc  <= QCW'(QBITS);
        end else if (i_cmd.div_iter) begin
            r_rem <= rem_ge ? {rem_sub[MW-1:0], 1'b0} : {r_rem[MW-1:0], 1'b0};
            r_q   <= {r_q[QBITS-2:0], rem_ge};
            r_qc  <= r_qc + QCW'(1);
        end
        if (i_cmd.div_fin) begin
            r_mm <= div_fp.m;
            r_me <= div_fp.e;
        end
        if (i_cmd.dexp_inc) begin
            r_dexp <= r_dexp + DEXP_W'(1);
        end else if (i_cmd.dexp_dec) begin
            r_dexp <= r_dexp - DEXP_W'(1);
        end
        if (i_cmd.out_load) begin
            r_oerr <= err;
            r_om   <= err ? 32'd0
                          : {1'b0, 8'(r_me) + 8'(BIAS), r_mm[MW-2:0]};
            r_oe   <= err ? 16'd0 : r_dexp;
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_sts.err      = err;
    assign o_sts.d_gt_k   = r_d > {1'b0, r_k};
    assign o_sts.cvt_norm = r_cs[SW-1];
    assign o_sts.div_done = (r_qc == QCW'(QBITS));
    assign o_sts.ge_ten   = (r_me > TEN_E) || ((r_me == TEN_E) && (r_mm >= TEN_M));
    assign o_sts.lt_one   = r_me < t_exp'(0);
    assign o_sts.out_free = !r_ov || i_ready;

    assign o_valid         = r_ov;
    assign o_mantissa_bits = r_om;
    assign o_exponent      = r_oe;
    assign o_range_error   = r_oerr;

endmodule

// ----- sv/binomial_coefficient_decimal_float.sv -----
// Sequence: when k is zero or k exceeds n, the accepted beat goes straight to the result;
//   otherwise the block runs k steps, each with int-to-float shifts, a multiply and a
//   26-bit shift-subtract divide, plus a divide-by-ten or multiply-by-ten per normalisation.
// Throughput: one item at a time; the next beat is taken once the result is in the output register.
// Reset: synchronous active low; clears the controller and the output valid, no clearing pass.
`include "binomial_coefficient_decimal_float_defines.svh"

module binomial_coefficient_decimal_float
    import bcdf_pkg::*;
#(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcdf_in_if.sink     i_in,
    bcdf_out_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;

    bcdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bcdf_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_n_value       (i_in.n_value),
        .i_k_value       (i_in.k_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_mantissa_bits (o_out.mantissa_bits),
        .o_exponent      (o_out.exponent),
        .o_range_error   (o_out.range_error)
    );

    `BCDF_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out.valid && o_out.range_error,
        o_out.mantissa_bits == 32'd0 && o_out.exponent == 16'sd0, "error beat not zero")
    `BCDF_ASSERT_IMP(a_mant_range, i_clk, i_rst_n, o_out.valid && !o_out.range_error,
        !o_out.mantissa_bits[31] && o_out.mantissa_bits[30:23] >= 8'd127
            && o_out.mantissa_bits[30:23] <= 8'd130, "mantissa outside [1,10]")
    `BCDF_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "ready after accepted beat")

endmodule

// ----- verif/tb_binomial_coefficient_decimal_float.sv -----
module tb_binomial_coefficient_decimal_float;
    import bcdf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  OPB       = 16;
    localparam int  NUM_RAND  = 600;
    localparam int  CALM_LEN  = 80;
    localparam int  LIMIT     = 30_000_000;

    typedef struct {
        logic [23:0] man;
        int          pow2;
    } t_sfloat;

    typedef struct {
        logic [31:0]        mant;
        logic signed [15:0] dexp;
        logic               err;
    } t_coef;

    typedef struct {
        logic [15:0] n;
        logic [15:0] k;
        bit          typed;
        t_coef       want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bcdf_in_if #(.W(OPB)) in_if();
    bcdf_out_if           out_if();

    binomial_coefficient_decimal_float #(.OPERAND_BITS(OPB)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    always #10 i_clk = ~i_clk;

    t_coef coef_q[$];
    t_coef typed_q[$];
    bit    typed_flag_q[$];
    int    fail_cnt = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;
    longint cyc = 0;

    function automatic t_sfloat round_single(input logic [63:0] v, input int ev,
                                             input bit sticky);
        t_sfloat     r;
        int          p;
        int          sh;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        p = 63;
        while (!v[p]) p--;
        if (p > 23) begin
            sh   = p - 23;
            keep = v >> sh;
            rem  = v & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && (sticky || keep[0])))
                keep = keep + 1;
            if (keep[24]) begin
                keep = keep >> 1;
                sh++;
            end
            r.man  = keep[23:0];
            r.pow2 = ev + sh;
        end else begin
            r.man  = 24'(v << (23 - p));
            r.pow2 = ev - (23 - p);
        end
        return r;
    endfunction

    function automatic t_sfloat fmul(input t_sfloat a, input t_sfloat b);
        return round_single(64'(a.man) * 64'(b.man), a.pow2 + b.pow2, 1'b0);
    endfunction

    function automatic t_sfloat fdiv(input t_sfloat a, input t_sfloat b);
        logic [63:0] num;
        num = 64'(a.man) << 30;
        return round_single(num / 64'(b.man), a.pow2 - b.pow2 - 30,
                            (num % 64'(b.man)) != 0);
    endfunction

    function automatic real fval(input t_sfloat a);
        return $itor(a.man) * (2.0 ** a.pow2);
    endfunction

    function automatic t_coef binom_sci(input logic [15:0] n, input logic [15:0] k);
        t_coef   r;
        t_sfloat m;
        t_sfloat ten;
        int      dexp;
        int      top;
        if (k > n) begin
            r.mant = '0;
            r.dexp = '0;
            r.err  = 1'b1;
            return r;
        end
        m    = round_single(64'd1, 0, 1'b0);
        ten  = round_single(64'd10, 0, 1'b0);
        dexp = 0;
        top  = n;
        for (int d = 1; d <= k; d++) begin
            m = fmul(m, round_single(64'(top), 0, 1'b0));
            m = fdiv(m, round_single(64'(d), 0, 1'b0));
            while (fval(m) >= 10.0) begin
                m = fdiv(m, ten);
                dexp++;
            end
            while (fval(m) < 1.0) begin
                m = fmul(m, ten);
                dexp--;
            end
            top--;
        end
        r.mant = {1'b0, 8'(m.pow2 + 23 + 127), m.man[22:0]};
        r.dexp = 16'(dexp);
        r.err  = 1'b0;
        return r;
    endfunction

    function automatic t_row mk(input int n, input int k, input bit typed,
                                input logic [31:0] mant, input int dexp, input bit err);
        t_row r;
        r.n = 16'(n);
        r.k = 16'(k);
        r.typed = typed;
        r.want.mant = mant;
        r.want.dexp = 16'(dexp);
        r.want.err = err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_coef want;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            want = binom_sci(in_if.n_value, in_if.k_value);
            if (typed_flag_q.size() != 0 && typed_flag_q[0]) begin
                if (typed_q[0] != want) begin
                    $error("table row n=%0d k=%0d disagrees with prediction",
                           in_if.n_value, in_if.k_value);
                    fail_cnt++;
                end
                want = typed_q[0];
            end
            if (typed_flag_q.size() != 0) begin
                void'(typed_flag_q.pop_front());
                void'(typed_q.pop_front());
            end
            coef_q.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        t_coef want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (coef_q.size() == 0) begin
                $error("unexpected result beat");
                fail_cnt++;
            end else begin
                want = coef_q.pop_front();
                if (out_if.mantissa_bits !== want.mant) begin
                    $error("mantissa_bits expected %h actual %h", want.mant,
                           out_if.mantissa_bits);
                    fail_cnt++;
                end
                if (out_if.exponent !== want.dexp) begin
                    $error("exponent expected %0d actual %0d", want.dexp,
                           out_if.exponent);
                    fail_cnt++;
                end
                if (out_if.range_error !== want.err) begin
                    $error("range_error expected %0b actual %0b", want.err,
                           out_if.range_error);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic send(input logic [15:0] n, input logic [15:0] k);
        in_if.valid   <= 1'b1;
        in_if.n_value <= n;
        in_if.k_value <= k;
        do @(posedge i_clk); while (!in_if.ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    t_row        rows[$];
    logic [15:0] rn;
    logic [15:0] rk;
    int          sel;

    initial begin
        in_if.valid   = 1'b0;
        in_if.n_value = '0;
        in_if.k_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk(0, 0, 1, 32'h3F80_0000, 0, 0));
        rows.push_back(mk(65535, 0, 1, 32'h3F80_0000, 0, 0));
        rows.push_back(mk(0, 1, 1, 32'h0, 0, 1));
        rows.push_back(mk(0, 65535, 1, 32'h0, 0, 1));
        rows.push_back(mk(65534, 65535, 1, 32'h0, 0, 1));
        rows.push_back(mk(32767, 32768, 1, 32'h0, 0, 1));
        rows.push_back(mk(1, 1, 1, 32'h3F80_0000, 0, 0));
        rows.push_back(mk(10, 1, 1, 32'h3F80_0000, 1, 0));
        rows.push_back(mk(65535, 1, 0, 0, 0, 0));
        rows.push_back(mk(65535, 2, 0, 0, 0, 0));
        rows.push_back(mk(65535, 7, 0, 0, 0, 0));
        rows.push_back(mk(32768, 3, 0, 0, 0, 0));
        rows.push_back(mk(10, 3, 0, 0, 0, 0));
        rows.push_back(mk(5, 5, 0, 0, 0, 0));
        rows.push_back(mk(20, 10, 0, 0, 0, 0));
        rows.push_back(mk(52, 5, 0, 0, 0, 0));
        rows.push_back(mk(99, 2, 0, 0, 0, 0));
        rows.push_back(mk(100, 50, 0, 0, 0, 0));
        rows.push_back(mk(1000, 500, 0, 0, 0, 0));
        rows.push_back(mk(43690, 21, 0, 0, 0, 0));
        rows.push_back(mk(21845, 12, 0, 0, 0, 0));

        foreach (rows[i]) begin
            typed_flag_q.push_back(rows[i].typed);
            typed_q.push_back(rows[i].want);
            send(rows[i].n, rows[i].k);
        end

        for (int i = 0; i < NUM_RAND; i++) begin
            if (i == NUM_RAND - CALM_LEN) calm = 1'b1;
            if (i == 150) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
                while (coef_q.size() != 0) @(posedge i_clk);
            end
            if (i == 300) hold_req = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                rn = 16'($urandom_range(0, 60));
                rk = 16'($urandom_range(0, rn + 2));
            end else if (sel < 85) begin
                rn = 16'($urandom);
                rk = 16'($urandom_range(0, 8));
            end else if (sel < 97) begin
                rk = 16'($urandom);
                rn = 16'($urandom);
                if (rk <= rn) begin
                    rn = rk;
                    rk = 16'($urandom_range(rn + 1, 65535));
                    if (rn == 16'hFFFF) rn = 16'hFFFE;
                    if (rk <= rn) rk = 16'hFFFF;
                end
            end else begin
                rn = 16'($urandom);
                rk = 16'($urandom_range(0, 150));
                if (rk > rn) rk = rn;
            end
            send(rn, rk);
        end
        in_if.valid <= 1'b0;

        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bcdf_pkg.sv
sv/bcdf_ifs.sv
sv/bcdf_ctrl.sv
sv/bcdf_dp.sv
sv/binomial_coefficient_decimal_float.sv
verif/tb_binomial_coefficient_decimal_float.sv
